FILE: design/lpc_pkg.sv
// ============================================================================
// lpc_pkg: shared types and constants for the LRU position cache
// Holds the operation codes, the controller state type, the command and status
// structs between controller and datapath, and the fixed field widths.
// ============================================================================
`default_nettype none

package lpc_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] OP_NEW_PASS = 2'd0;
   localparam logic [1:0] OP_REQUEST  = 2'd1;
   localparam logic [1:0] OP_REPORT   = 2'd2;

   // Fixed field widths.
   localparam int OP_W    = 2;
   localparam int KEY_W   = 32;
   localparam int FRAME_W = 24;
   localparam int POS_W   = 25;
   localparam int PASS_W  = 32;
   localparam int SEEK_W  = 32;
   localparam int SLOT_W  = 3;
   localparam int OCC_OUT_W = 4;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;

   // Stored position meaning "unknown": never equals frame plus one.
   localparam logic [POS_W-1:0] POS_UNKNOWN = {POS_W{1'b1}};
   localparam logic [31:0]      ALL_ONES32  = 32'hFFFF_FFFF;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // latch the incoming request and clear scan results
      logic scan_rd;  // read the table entry at the scan address
      logic commit;   // apply the update and load the response register
   } lpc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_is_request; // incoming request carries the lookup opcode
      logic out_busy;      // response register holds a result not yet taken
   } lpc_status_type;

endpackage

`default_nettype wire

FILE: design/lru_position_cache.sv
// ============================================================================
// lru_position_cache: fully associative LRU table of stream positions
// Top level joining the sequencing controller and the table datapath.
// ============================================================================
// Usage:
//   Requests arrive on the req_ stream; req_tuser carries the opcode (new pass,
//   lookup, decode report) and req_tdata the remaining fields. Each request
//   yields exactly one response on the rsp_ stream.
//   A lookup scans the table one entry per cycle through the single read port
//   of the table memories, so it passes through accept, a scan of every
//   entry and commit. New-pass and report requests go through accept and
//   commit only. The response is valid the cycle after the commit.
//   The response sits in an output register; the next request is accepted
//   while it waits, and a commit holds until the receiver takes the previous
//   response, so a stalled receiver stalls the block after one request.
//   Reset (synchronous, active high) empties the table and clears the pass
//   and seek counters; no clearing pass over the memories is needed.
// ============================================================================
`default_nettype none

module lru_position_cache #(
   parameter int ENTRIES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: key_id[31:0], wanted_frame[55:32], open_ok[56],
   // report_slot[59:57], seek_done[60], decode_ok[61], zero fill [63:62].
   input  wire logic [63:0] req_tdata,
   // Fields from bit 0: op[1:0].
   input  wire logic [1:0]  req_tuser,
   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: hit[0], slot[3:1], installed[4], need_seek[5],
   // evicted[6], evicted_key[38:7], occupancy[42:39], seek_total[74:43],
   // zero fill [79:75].
   output logic [79:0]      rsp_tdata
);
   import lpc_pkg::*;

   lpc_cmd_type              cmd;
   lpc_status_type           status;
   logic [$clog2(ENTRIES)-1:0] scan_addr;

   lpc_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .scan_addr  (scan_addr)
   );

   lpc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .scan_addr  (scan_addr),
      .status     (status)
   );

endmodule

`default_nettype wire

FILE: design/lpc_ctrl.sv
// ============================================================================
// lpc_ctrl: sequencing state machine for the LRU position cache
// Accepts one request at a time, steps the table scan for lookups and issues
// the commit once the response register is free.
// ============================================================================
`default_nettype none

module lpc_ctrl #(
   parameter int ENTRIES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire lpc_pkg::lpc_status_type       status,
   output lpc_pkg::lpc_cmd_type               cmd,
   output logic [$clog2(ENTRIES)-1:0]         scan_addr
);
   import lpc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // State and scan counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign scan_addr = cnt_ff[IDX_W-1:0];

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.in_is_request ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            // One entry is read per cycle; the last compare lands when the
            // counter reaches the entry count.
            cnt_in      = cnt_ff + CNT_W'(1);
            cmd.scan_rd = (cnt_ff < CNT_W'(ENTRIES));
            if (cnt_ff == CNT_W'(ENTRIES)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/lpc_datapath.sv
// ============================================================================
// lpc_datapath: table storage, scan compare and update logic
// Holds the key, position and pass memories, the valid bits, the pass and
// seek counters, the scan results and the response register.
// ============================================================================
`default_nettype none

module lpc_datapath #(
   parameter int ENTRIES = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [lpc_pkg::OP_W-1:0]            req_tuser,
   input  wire logic [lpc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lpc_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire lpc_pkg::lpc_cmd_type                cmd,
   input  wire logic [$clog2(ENTRIES)-1:0]          scan_addr,
   output lpc_pkg::lpc_status_type                  status
);
   import lpc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);

   // Table memories and valid bits.
   logic [KEY_W-1:0]  key_mem  [ENTRIES];
   logic [POS_W-1:0]  pos_mem  [ENTRIES];
   logic [PASS_W-1:0] pass_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   // Latched request fields.
   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic               open_ok_ff;
   logic [SLOT_W-1:0]  rslot_ff;
   logic               seek_done_ff;
   logic               decode_ok_ff;

   // Counters.
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [SEEK_W-1:0] seek_ff, seek_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   // Registered read stage of the scan.
   logic              rd_en_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [KEY_W-1:0]  key_rd_ff;
   logic [POS_W-1:0]  pos_rd_ff;
   logic [PASS_W-1:0] pass_rd_ff;

   // Scan results.
   logic              found_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [POS_W-1:0]  hit_pos_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              have_vic_ff;
   logic [IDX_W-1:0]  vic_idx_ff;
   logic [PASS_W-1:0] vic_pass_ff;
   logic [KEY_W-1:0]  vic_key_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Commit outputs.
   logic              key_we, pos_we, pass_we, valid_set;
   logic [IDX_W-1:0]  w_idx;
   logic [POS_W-1:0]  w_pos;
   logic              r_hit, r_installed, r_need_seek, r_evicted;
   logic [IDX_W-1:0]  r_slot;
   logic [KEY_W-1:0]  r_evicted_key;
   logic              rslot_ok;
   logic [IDX_W-1:0]  rslot_idx;
   logic              entry_valid_rd;
   logic              better_vic;

   assign status.in_is_request = (req_tuser == OP_REQUEST);
   assign status.out_busy      = rsp_valid_ff && !rsp_tready;

   // Latch the fields of an accepted request.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_tuser;
         key_ff       <= req_tdata[31:0];
         frame_ff     <= req_tdata[55:32];
         open_ok_ff   <= req_tdata[56];
         rslot_ff     <= req_tdata[59:57];
         seek_done_ff <= req_tdata[60];
         decode_ok_ff <= req_tdata[61];
      end
   end

   // Table memories: one write address, one registered read address.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[w_idx] <= key_ff;
      end
      if (pos_we) begin
         pos_mem[w_idx] <= w_pos;
      end
      if (pass_we) begin
         pass_mem[w_idx] <= pass_ff;
      end
      if (cmd.scan_rd) begin
         key_rd_ff  <= key_mem[scan_addr];
         pos_rd_ff  <= pos_mem[scan_addr];
         pass_rd_ff <= pass_mem[scan_addr];
         rd_idx_ff  <= scan_addr;
      end
   end

   // Compare stage of the scan: first match, first free slot, oldest entry.
   assign entry_valid_rd = valid_ff[rd_idx_ff];
   assign better_vic = !have_vic_ff || (pass_rd_ff < vic_pass_ff) ||
                       ((pass_rd_ff == vic_pass_ff) && (key_rd_ff < vic_key_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff      <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         have_vic_ff   <= 1'b0;
      end else begin
         rd_en_ff <= cmd.scan_rd;
         if (cmd.accept) begin
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
            have_vic_ff   <= 1'b0;
         end else if (rd_en_ff) begin
            if (entry_valid_rd && (key_rd_ff == key_ff) && !found_ff) begin
               found_ff <= 1'b1;
            end
            if (!entry_valid_rd && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
            if (entry_valid_rd && better_vic) begin
               have_vic_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en_ff) begin
         if (entry_valid_rd && (key_rd_ff == key_ff) && !found_ff) begin
            hit_idx_ff <= rd_idx_ff;
            hit_pos_ff <= pos_rd_ff;
         end
         if (!entry_valid_rd && !free_found_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
         if (entry_valid_rd && better_vic) begin
            vic_idx_ff  <= rd_idx_ff;
            vic_pass_ff <= pass_rd_ff;
            vic_key_ff  <= key_rd_ff;
         end
      end
   end

   // Report slot decode: slots past the table size are ignored.
   assign rslot_ok  = (32'(rslot_ff) < ENTRIES);
   assign rslot_idx = IDX_W'(rslot_ff);

   // Update decision for the item being committed.
   always_comb begin
      key_we        = 1'b0;
      pos_we        = 1'b0;
      pass_we       = 1'b0;
      valid_set     = 1'b0;
      w_idx         = '0;
      w_pos         = POS_UNKNOWN;
      r_hit         = 1'b0;
      r_installed   = 1'b0;
      r_need_seek   = 1'b0;
      r_evicted     = 1'b0;
      r_slot        = '0;
      r_evicted_key = '0;
      pass_in       = pass_ff;
      seek_in       = seek_ff;
      occ_in        = occ_ff;
      if (cmd.commit) begin
         case (op_ff)
            OP_NEW_PASS: begin
               if (pass_ff != ALL_ONES32) begin
                  pass_in = pass_ff + PASS_W'(1);
               end
            end
            OP_REQUEST: begin
               if (found_ff) begin
                  // Hit: refresh the pass number only.
                  pass_we     = 1'b1;
                  w_idx       = hit_idx_ff;
                  r_hit       = 1'b1;
                  r_installed = 1'b1;
                  r_slot      = hit_idx_ff;
                  r_need_seek = (hit_pos_ff != {1'b0, frame_ff});
               end else if (open_ok_ff) begin
                  // Miss with a new source: take a free slot or the oldest entry.
                  key_we      = 1'b1;
                  pos_we      = 1'b1;
                  pass_we     = 1'b1;
                  valid_set   = 1'b1;
                  w_idx       = free_found_ff ? free_idx_ff : vic_idx_ff;
                  w_pos       = POS_UNKNOWN;
                  r_installed = 1'b1;
                  r_slot      = w_idx;
                  r_need_seek = 1'b1;
                  if (free_found_ff) begin
                     occ_in = occ_ff + OCC_W'(1);
                  end else begin
                     r_evicted     = 1'b1;
                     r_evicted_key = vic_key_ff;
                  end
               end
            end
            OP_REPORT: begin
               if (rslot_ok && valid_ff[rslot_idx]) begin
                  pos_we = 1'b1;
                  w_idx  = rslot_idx;
                  w_pos  = decode_ok_ff ? (POS_W'(frame_ff) + POS_W'(1)) : POS_UNKNOWN;
                  if (seek_done_ff && (seek_ff != ALL_ONES32)) begin
                     seek_in = seek_ff + SEEK_W'(1);
                  end
               end
            end
            default: begin
               // Unused opcode: no state change.
            end
         endcase
      end
   end

   // Response payload, highest field first.
   assign rsp_data_in = {5'd0, seek_in, OCC_OUT_W'(occ_in), r_evicted_key, r_evicted,
                         r_need_seek, r_installed, SLOT_W'(r_slot), r_hit};

   // Counters, valid bits and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pass_ff      <= '0;
         seek_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pass_ff <= pass_in;
         seek_ff <= seek_in;
         occ_ff  <= occ_in;
         if (valid_set) begin
            valid_ff[w_idx] <= 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill count tracks the valid bits.
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy count differs from valid bits");

   // A commit never overwrites a result that is still waiting.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("commit while response register busy");

   // An eviction only comes with a fresh install on a full table.
   a_evict_install: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && r_evicted) |-> (r_installed && !r_hit && !free_found_ff &&
                                     occ_ff == OCC_W'(ENTRIES)))
      else $error("eviction without a full-table install");

   // Each scan compare follows its read in the next cycle.
   a_scan_trail: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |=> rd_en_ff)
      else $error("scan read not followed by compare");

endmodule

`default_nettype wire
